FILE: sv/rama_pkg.sv
// Shared types and constants for the rack-aware machine allocator.
`default_nettype none
package rama_pkg;

  localparam int NUM_RACKS         = 4;
  localparam int MACHINES_PER_RACK = 16;
  localparam int MAX_GRANT         = 64;
  localparam int COUNT_W           = 7;
  localparam int ID_W              = 6;

  localparam logic KIND_RELEASE = 1'b1;
  localparam logic JOB_MPI      = 1'b0;

  typedef enum logic [2:0] {
    ST_GRANT    = 3'd0,
    ST_NOFREE   = 3'd1,
    ST_HARD     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_BAD      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REL,
    S_CNT,
    S_CHK,
    S_GRD,
    S_GRT,
    S_EMIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic               kind;
    logic               job_type;
    logic [COUNT_W-1:0] count;
    logic [ID_W-1:0]    machine_id;
  } req_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] granted_machine;
    logic            preferred;
    logic            last;
  } rsp_t;

  typedef struct packed {
    logic set;
    logic clr;
  } map_op_t;

endpackage
`default_nettype wire

FILE: sv/rack_aware_machine_allocator.sv
// Top level of the rack-aware machine allocator: policy register, output register, core.
// Release: a rack sweep on one compare unit, ending at the hit rack or the last rack.
// Allocate: a count sweep, a check, then for a hard spread greedy sweeps, each with a
// grant step; then one grant per cycle while the output is not stalled, skipping empty racks.
// One transaction at a time; the input stalls until its last result is registered.
// Synchronous rst marks every machine free and sets soft_policy to 1; no clearing pass.
`default_nettype none
module rack_aware_machine_allocator #(
  parameter int NUM_RACKS         = rama_pkg::NUM_RACKS,
  parameter int MACHINES_PER_RACK = rama_pkg::MACHINES_PER_RACK,
  localparam int RW  = $clog2(NUM_RACKS),
  localparam int SW  = (MACHINES_PER_RACK > 1) ? $clog2(MACHINES_PER_RACK) : 1,
  localparam int FCW = $clog2(MACHINES_PER_RACK + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire rama_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output rama_pkg::rsp_t      rsp,
  input  wire logic           cfg_we,
  input  wire logic           cfg_data
);

  logic              soft_policy;
  logic              out_free;
  logic              rsp_load;
  rama_pkg::rsp_t    rsp_data;
  logic [RW-1:0]     map_rack;
  logic [SW-1:0]     map_slot;
  rama_pkg::map_op_t map_op;
  logic [FCW-1:0]    map_pop;
  logic [SW-1:0]     map_low;
  logic              map_any;

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_policy <= 1'b1;
    end else if (cfg_we) begin
      soft_policy <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_data;
    end
  end

  rama_seq #(
    .NUM_RACKS         (NUM_RACKS),
    .MACHINES_PER_RACK (MACHINES_PER_RACK)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .soft_policy (soft_policy),
    .out_free    (out_free),
    .rsp_load    (rsp_load),
    .rsp_data    (rsp_data),
    .map_rack    (map_rack),
    .map_slot    (map_slot),
    .map_op      (map_op),
    .map_pop     (map_pop),
    .map_low     (map_low),
    .map_any     (map_any)
  );

  rama_map #(
    .NUM_RACKS         (NUM_RACKS),
    .MACHINES_PER_RACK (MACHINES_PER_RACK)
  ) u_map (
    .clk  (clk),
    .rst  (rst),
    .rack (map_rack),
    .slot (map_slot),
    .op   (map_op),
    .pop  (map_pop),
    .low  (map_low),
    .any  (map_any)
  );

endmodule
`default_nettype wire

FILE: sv/rama_map.sv
// Free-machine map: one row per rack, with popcount and lowest-free-slot search on one row.
`default_nettype none
module rama_map #(
  parameter int NUM_RACKS         = rama_pkg::NUM_RACKS,
  parameter int MACHINES_PER_RACK = rama_pkg::MACHINES_PER_RACK,
  localparam int RW  = $clog2(NUM_RACKS),
  localparam int SW  = (MACHINES_PER_RACK > 1) ? $clog2(MACHINES_PER_RACK) : 1,
  localparam int FCW = $clog2(MACHINES_PER_RACK + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [RW-1:0]    rack,
  input  wire logic [SW-1:0]    slot,
  input  wire rama_pkg::map_op_t op,
  output logic      [FCW-1:0]   pop,
  output logic      [SW-1:0]    low,
  output logic                  any
);

  logic [MACHINES_PER_RACK-1:0] row [NUM_RACKS];
  logic [MACHINES_PER_RACK-1:0] sel;

  assign sel = row[rack];
  assign any = |sel;

  always_comb begin
    pop = '0;
    low = '0;
    for (int i = 0; i < MACHINES_PER_RACK; i++) begin
      pop = pop + FCW'(sel[i]);
    end
    for (int i = MACHINES_PER_RACK - 1; i >= 0; i--) begin
      if (sel[i]) begin
        low = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_RACKS; i++) begin
        row[i] <= '1;
      end
    end else if (op.set) begin
      row[rack][slot] <= 1'b1;
    end else if (op.clr) begin
      row[rack][low] <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rama_seq.sv
// Sequencer: rack sweeps for release, count, fit search, greedy spread and grant emission.
`default_nettype none
module rama_seq #(
  parameter int NUM_RACKS         = rama_pkg::NUM_RACKS,
  parameter int MACHINES_PER_RACK = rama_pkg::MACHINES_PER_RACK,
  localparam int RW   = $clog2(NUM_RACKS),
  localparam int SW   = (MACHINES_PER_RACK > 1) ? $clog2(MACHINES_PER_RACK) : 1,
  localparam int FCW  = $clog2(MACHINES_PER_RACK + 1),
  localparam int TOTW = $clog2(NUM_RACKS * MACHINES_PER_RACK + 1),
  localparam int CMPW = (TOTW > rama_pkg::COUNT_W) ? TOTW : rama_pkg::COUNT_W,
  localparam int BW   = TOTW + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire rama_pkg::req_t    req,
  input  wire logic              soft_policy,
  input  wire logic              out_free,
  output logic                   rsp_load,
  output rama_pkg::rsp_t         rsp_data,
  output logic      [RW-1:0]     map_rack,
  output logic      [SW-1:0]     map_slot,
  output rama_pkg::map_op_t      map_op,
  input  wire logic [FCW-1:0]    map_pop,
  input  wire logic [SW-1:0]     map_low,
  input  wire logic              map_any
);

  rama_pkg::state_t  state, state_next;
  rama_pkg::req_t    rq;
  rama_pkg::status_t rsp_st;
  logic [rama_pkg::ID_W-1:0]    rsp_id;
  logic [RW-1:0]                r;
  logic [TOTW-1:0]              base;
  logic [TOTW-1:0]              total;
  logic [FCW-1:0]               fc [NUM_RACKS];
  logic [FCW-1:0]               tk [NUM_RACKS];
  logic [RW-1:0]                best;
  logic [FCW-1:0]               bmin;
  logic                         best_vld;
  logic [RW-1:0]                idx;
  logic [FCW-1:0]               mn;
  logic                         idx_vld;
  logic [rama_pkg::COUNT_W-1:0] rem;
  logic [rama_pkg::COUNT_W-1:0] left;
  logic                         pref;

  logic [CMPW-1:0] cnt;
  logic [FCW-1:0]  fc_r, fc_idx, tk_r, take_t;
  logic            rack_last;
  logic [BW-1:0]   id_c, base_c, lim;
  logic            rel_hit;
  logic [SW-1:0]   rel_slot;
  logic            mpi_better, grd_better, left_one;

  assign cnt        = CMPW'(rq.count);
  assign fc_r       = fc[r];
  assign fc_idx     = fc[idx];
  assign tk_r       = tk[r];
  assign rack_last  = (r == RW'(NUM_RACKS - 1));
  assign id_c       = BW'(rq.machine_id);
  assign base_c     = BW'(base);
  assign lim        = base_c + BW'(MACHINES_PER_RACK);
  assign rel_hit    = (id_c < lim);
  assign rel_slot   = SW'(id_c - base_c);
  assign mpi_better = (rq.job_type == rama_pkg::JOB_MPI) && (r != '0) &&
                      (CMPW'(map_pop) >= cnt) && (!best_vld || map_pop < bmin);
  assign grd_better = (fc_r != '0) && (!idx_vld || fc_r <= mn);
  assign take_t     = (CMPW'(fc_idx) <= CMPW'(rem)) ? fc_idx : FCW'(rem);
  assign left_one   = (left == rama_pkg::COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rama_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    rsp_load   = 1'b0;
    rsp_data   = '{status: rsp_st, granted_machine: rsp_id, preferred: 1'b0, last: 1'b1};
    map_rack   = r;
    map_slot   = rel_slot;
    map_op     = '0;
    case (state)
      rama_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          if (req.kind == rama_pkg::KIND_RELEASE) begin
            state_next = rama_pkg::S_REL;
          end else if (req.count == '0 ||
                       req.count > rama_pkg::COUNT_W'(rama_pkg::MAX_GRANT)) begin
            state_next = rama_pkg::S_RESP;
          end else begin
            state_next = rama_pkg::S_CNT;
          end
        end
      end
      rama_pkg::S_REL: begin
        if (rel_hit) begin
          map_op.set = 1'b1;
          state_next = rama_pkg::S_RESP;
        end else if (rack_last) begin
          state_next = rama_pkg::S_RESP;
        end
      end
      rama_pkg::S_CNT: begin
        if (rack_last) begin
          state_next = rama_pkg::S_CHK;
        end
      end
      rama_pkg::S_CHK: begin
        if (cnt > CMPW'(total)) begin
          state_next = rama_pkg::S_RESP;
        end else if (best_vld || CMPW'(fc[0]) >= cnt) begin
          state_next = rama_pkg::S_EMIT;
        end else if (!soft_policy) begin
          state_next = rama_pkg::S_RESP;
        end else begin
          state_next = rama_pkg::S_GRD;
        end
      end
      rama_pkg::S_GRD: begin
        if (rack_last) begin
          state_next = rama_pkg::S_GRT;
        end
      end
      rama_pkg::S_GRT: begin
        if (CMPW'(rem) == CMPW'(take_t)) begin
          state_next = rama_pkg::S_EMIT;
        end else begin
          state_next = rama_pkg::S_GRD;
        end
      end
      rama_pkg::S_EMIT: begin
        if (tk_r != '0 && out_free) begin
          rsp_load   = 1'b1;
          rsp_data   = '{status: rama_pkg::ST_GRANT,
                         granted_machine: rama_pkg::ID_W'(base + TOTW'(map_low)),
                         preferred: pref, last: left_one};
          map_op.clr = 1'b1;
          if (left_one) begin
            state_next = rama_pkg::S_IDLE;
          end
        end
      end
      rama_pkg::S_RESP: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = rama_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rama_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      rama_pkg::S_IDLE: begin
        if (req_valid) begin
          rq       <= req;
          r        <= '0;
          base     <= '0;
          total    <= '0;
          best_vld <= 1'b0;
          idx_vld  <= 1'b0;
          rsp_st   <= rama_pkg::ST_BAD;
          rsp_id   <= '0;
          for (int i = 0; i < NUM_RACKS; i++) begin
            tk[i] <= '0;
          end
        end
      end
      rama_pkg::S_REL: begin
        if (rel_hit) begin
          rsp_st <= rama_pkg::ST_RELEASED;
          rsp_id <= rq.machine_id;
        end else if (!rack_last) begin
          r    <= RW'(r + 1'b1);
          base <= TOTW'(lim);
        end
      end
      rama_pkg::S_CNT: begin
        fc[r] <= map_pop;
        total <= total + TOTW'(map_pop);
        if (mpi_better) begin
          best     <= r;
          bmin     <= map_pop;
          best_vld <= 1'b1;
        end
        r <= rack_last ? '0 : RW'(r + 1'b1);
      end
      rama_pkg::S_CHK: begin
        left <= rq.count;
        base <= '0;
        r    <= '0;
        if (cnt > CMPW'(total)) begin
          rsp_st <= rama_pkg::ST_NOFREE;
        end else if (best_vld) begin
          tk[best] <= FCW'(rq.count);
          pref     <= 1'b1;
        end else if (CMPW'(fc[0]) >= cnt) begin
          tk[0] <= FCW'(rq.count);
          pref  <= 1'b1;
        end else begin
          pref    <= 1'b0;
          rsp_st  <= rama_pkg::ST_HARD;
          rem     <= rq.count;
          idx_vld <= 1'b0;
        end
      end
      rama_pkg::S_GRD: begin
        if (grd_better) begin
          idx     <= r;
          mn      <= fc_r;
          idx_vld <= 1'b1;
        end
        r <= rack_last ? '0 : RW'(r + 1'b1);
      end
      rama_pkg::S_GRT: begin
        tk[idx] <= take_t;
        fc[idx] <= '0;
        rem     <= rem - rama_pkg::COUNT_W'(take_t);
        idx_vld <= 1'b0;
      end
      rama_pkg::S_EMIT: begin
        if (tk_r == '0) begin
          r    <= RW'(r + 1'b1);
          base <= base + TOTW'(MACHINES_PER_RACK);
        end else if (out_free) begin
          tk[r] <= tk_r - 1'b1;
          left  <= left - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> out_free)
    else $error("result loaded while output register busy");

  a_grant_free_slot: assert property (@(posedge clk) disable iff (rst)
    (state == rama_pkg::S_EMIT && rsp_load) |-> map_any)
    else $error("grant from a rack with no free slot");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> state != rama_pkg::S_IDLE)
    else $error("accepted transaction did not start");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && rsp_data.last) |=> state == rama_pkg::S_IDLE)
    else $error("work continued after last result");

  a_emit_left: assert property (@(posedge clk) disable iff (rst)
    (state == rama_pkg::S_EMIT) |-> left != '0)
    else $error("emission with no grants left");

endmodule
`default_nettype wire
